>>> rtl/pcpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpg_pkg
// shared types, codes, constants and the cell distance function of the pulsed checkerboard pixel generator
// ----------------------------------------------------------------------------
package pcpg_pkg;

    localparam int COORD_WIDTH_DEF = 10;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_PIXEL = 2'd2;

    // register indexes
    localparam logic [2:0] REG_RED   = 3'd0;
    localparam logic [2:0] REG_GREEN = 3'd1;
    localparam logic [2:0] REG_BLUE  = 3'd2;
    localparam logic [2:0] REG_ALPHA = 3'd3;
    localparam logic [2:0] REG_FLASH = 3'd4;

    localparam logic [7:0]  COLOR_RST = 8'd255;
    localparam logic [15:0] FLASH_RST = 16'd200;

    // q8 fixed point
    localparam int          FRAC_BITS = 8;
    localparam logic [8:0]  Q8_ONE    = 9'd256;
    localparam logic [9:0]  BASS_MIN  = 10'd38;
    localparam logic [9:0]  BASS_MAX  = 10'd256;

    // pixel shape breakpoints
    localparam logic signed [11:0] P_RAMP_UP   = 12'sd128;
    localparam logic signed [11:0] P_FULL_END  = 12'sd384;
    localparam logic signed [11:0] P_RAMP_END  = 12'sd512;
    localparam logic [10:0]        CELL_CENTER = 11'd896;

    typedef struct packed {
        logic       done;
        logic [8:0] ratio;
    } div_status_t;

    // distance of a cell column from the cell center, q8
    function automatic logic [9:0] cell_dist(input logic [2:0] k);
        logic [10:0] t;
        t = {k, 8'b0};
        return k[2] ? 10'(t - CELL_CENTER) : 10'(CELL_CENTER - t);
    endfunction

endpackage

>>> rtl/pcpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpg_div
// iterative fade ratio divider, one compare and subtract step per cycle
// ----------------------------------------------------------------------------
module pcpg_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [15:0]           num,
    input  logic [15:0]           divisor,
    output pcpg_pkg::div_status_t status
);

    localparam int STEPS = pcpg_pkg::FRAC_BITS;

    logic [16:0] rem_reg, rem_next;
    logic [8:0]  quo_reg, quo_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [17:0] diff;
    logic        ge;

    // shared compare and subtract
    assign diff = {1'b0, rem_reg} - {2'b0, divisor};
    assign ge   = !diff[17];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, num};
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                // ratio saturates when the timer is not below the flash length; a zero timer with zero flash gives zero
                if (divisor == '0)
                begin
                    quo_next  = (rem_reg != '0) ? pcpg_pkg::Q8_ONE : '0;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else if (ge)
                begin
                    quo_next  = pcpg_pkg::Q8_ONE;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    rem_next = {rem_reg[15:0], 1'b0};
                    cnt_next = 4'd1;
                end
            end
            else
            begin
                quo_next = {quo_reg[7:0], ge};
                rem_next = {(ge ? diff[15:0] : rem_reg[15:0]), 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(STEPS))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign status.done  = done_reg;
    assign status.ratio = quo_reg;

endmodule

>>> rtl/pcpg_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpg_shade
// checkerboard pixel shading: square shape, fade and color scaling
// ----------------------------------------------------------------------------
module pcpg_shade #(
    parameter int COORD_WIDTH = pcpg_pkg::COORD_WIDTH_DEF
) (
    input  logic [COORD_WIDTH-1:0] px,
    input  logic [COORD_WIDTH-1:0] py,
    input  logic [10:0]            square_size,
    input  logic [8:0]             fade,
    input  logic [7:0]             c_red,
    input  logic [7:0]             c_green,
    input  logic [7:0]             c_blue,
    input  logic [7:0]             c_alpha,
    output logic [7:0]             s_red,
    output logic [7:0]             s_green,
    output logic [7:0]             s_blue,
    output logic [7:0]             s_alpha
);

    logic                lit;
    logic [9:0]          dx, dy, d;
    logic signed [11:0]  p, v, fade_s;
    logic [8:0]          a;
    logic [16:0]         pr_r, pr_g, pr_b, pr_a;

    assign lit    = (px[3] == py[3]);
    assign dx     = pcpg_pkg::cell_dist(px[2:0]);
    assign dy     = pcpg_pkg::cell_dist(py[2:0]);
    assign d      = (dx > dy) ? dx : dy;
    assign p      = $signed({1'b0, square_size}) - $signed({2'b0, d});
    assign fade_s = $signed({3'b0, fade});

    always_comb
    begin
        priority if (p < 12'sd0)
            v = fade_s;
        else if (p < pcpg_pkg::P_RAMP_UP)
            v = fade_s + (p <<< 1);
        else if (p < pcpg_pkg::P_FULL_END)
            v = $signed({3'b0, pcpg_pkg::Q8_ONE});
        else if (p < pcpg_pkg::P_RAMP_END)
            v = fade_s + ((pcpg_pkg::P_RAMP_END - p) <<< 1);
        else
            v = fade_s;
    end

    // v is never negative here
    always_comb
    begin
        if (!lit)
            a = '0;
        else if (v > $signed({3'b0, pcpg_pkg::Q8_ONE}))
            a = pcpg_pkg::Q8_ONE;
        else
            a = v[8:0];
    end

    assign pr_r = c_red   * a;
    assign pr_g = c_green * a;
    assign pr_b = c_blue  * a;
    assign pr_a = c_alpha * a;

    assign s_red   = pr_r[15:8];
    assign s_green = pr_g[15:8];
    assign s_blue  = pr_b[15:8];
    assign s_alpha = pr_a[15:8];

endmodule

>>> rtl/pulse_checkerboard_pixel_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_checkerboard_pixel_gen
// audio-pulsed checkerboard of 8x8 pixel cells, one rgba word per pixel request
//
// channel  dir  handshake                 payload
// in       in   in_valid / in_ready       req_type bass_energy peak_detected
//                                         pixel_x pixel_y
// out      out  out_valid / out_ready     out_red out_green out_blue out_alpha
// apb      in   psel penable pready       paddr pwrite pwdata prdata
//
// tick and pixel words need no sequencer state; a pixel result sits in the output
// register the cycle after acceptance
// frame start: the fade ratio divider runs one step per cycle (up to 9 steps),
// then the square state squares the ratio into the fade level
// in_ready is low while a frame start is in progress or a pixel result stalls
// reset clears timer, square size and fade, color to 255 and flash to 200
// ----------------------------------------------------------------------------
module pulse_checkerboard_pixel_gen #(
    parameter int COORD_WIDTH = pcpg_pkg::COORD_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             req_type,
    input  logic [9:0]             bass_energy,
    input  logic                   peak_detected,
    input  logic [COORD_WIDTH-1:0] pixel_x,
    input  logic [COORD_WIDTH-1:0] pixel_y,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_red,
    output logic [7:0]             out_green,
    output logic [7:0]             out_blue,
    output logic [7:0]             out_alpha,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_SQUARE = 3'b100
    } state_t;

    state_t      state_reg, state_next;

    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic [15:0] flash_reg;
    logic [15:0] timer_reg, timer_next;
    logic [10:0] size_reg, size_next;
    logic [8:0]  fade_reg, fade_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  ored_reg, ogreen_reg, oblue_reg, oalpha_reg;

    logic        accept;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        div_start;
    logic [15:0] div_num;
    logic [9:0]  bass_c;
    logic [17:0] sq;
    logic [7:0]  s_red, s_green, s_blue, s_alpha;

    pcpg_pkg::div_status_t div_stat;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg   <= pcpg_pkg::COLOR_RST;
            green_reg <= pcpg_pkg::COLOR_RST;
            blue_reg  <= pcpg_pkg::COLOR_RST;
            alpha_reg <= pcpg_pkg::COLOR_RST;
            flash_reg <= pcpg_pkg::FLASH_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                pcpg_pkg::REG_RED:   red_reg   <= pwdata[7:0];
                pcpg_pkg::REG_GREEN: green_reg <= pwdata[7:0];
                pcpg_pkg::REG_BLUE:  blue_reg  <= pwdata[7:0];
                pcpg_pkg::REG_ALPHA: alpha_reg <= pwdata[7:0];
                pcpg_pkg::REG_FLASH: flash_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            pcpg_pkg::REG_RED:   prdata = {24'b0, red_reg};
            pcpg_pkg::REG_GREEN: prdata = {24'b0, green_reg};
            pcpg_pkg::REG_BLUE:  prdata = {24'b0, blue_reg};
            pcpg_pkg::REG_ALPHA: prdata = {24'b0, alpha_reg};
            pcpg_pkg::REG_FLASH: prdata = {16'b0, flash_reg};
            default:             prdata = '0;
        endcase
    end

    // input side
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (bass_energy < pcpg_pkg::BASS_MIN)
            bass_c = pcpg_pkg::BASS_MIN;
        else if (bass_energy > pcpg_pkg::BASS_MAX)
            bass_c = pcpg_pkg::BASS_MAX;
        else
            bass_c = bass_energy;
    end

    assign div_num   = peak_detected ? flash_reg : timer_reg;
    assign div_start = accept && (req_type == pcpg_pkg::REQ_FRAME);

    pcpg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (div_num),
        .divisor (flash_reg),
        .status  (div_stat)
    );

    assign sq = div_stat.ratio * div_stat.ratio;

    pcpg_shade #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_shade (
        .px          (pixel_x),
        .py          (pixel_y),
        .square_size (size_reg),
        .fade        (fade_reg),
        .c_red       (red_reg),
        .c_green     (green_reg),
        .c_blue      (blue_reg),
        .c_alpha     (alpha_reg),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .s_alpha     (s_alpha)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        timer_next     = timer_reg;
        size_next      = size_reg;
        fade_next      = fade_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == pcpg_pkg::REQ_TICK)
                    begin
                        if (timer_reg != '0)
                            timer_next = timer_reg - 16'd1;
                    end
                    else if (req_type == pcpg_pkg::REQ_FRAME)
                    begin
                        size_next  = {bass_c[8:0], 2'b0};
                        timer_next = div_num;
                        state_next = ST_DIV;
                    end
                    else if (req_type == pcpg_pkg::REQ_PIXEL)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                fade_next  = sq[16:8];
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timer_reg     <= '0;
            size_reg      <= '0;
            fade_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            timer_reg     <= timer_next;
            size_reg      <= size_next;
            fade_reg      <= fade_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (accept && (req_type == pcpg_pkg::REQ_PIXEL))
        begin
            ored_reg   <= s_red;
            ogreen_reg <= s_green;
            oblue_reg  <= s_blue;
            oalpha_reg <= s_alpha;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = ored_reg;
    assign out_green = ogreen_reg;
    assign out_blue  = oblue_reg;
    assign out_alpha = oalpha_reg;

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_frame_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIV))
        else $error("frame start did not enter the divide phase");

    a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
        fade_reg <= pcpg_pkg::Q8_ONE)
        else $error("fade level above one");

endmodule
